// File: hw/rtl/pcni_pkg.sv
// ----------------------------------------------------------------------------
// pcni_pkg
// Shared widths, codes and slot offset tables for the periodic cell
// neighbour index block.
// ----------------------------------------------------------------------------
`default_nettype none

package pcni_pkg;

  localparam int unsigned COORD_W     = 6;
  localparam int unsigned CFG_W       = 7;
  localparam int unsigned IDX_W       = 18;
  localparam int unsigned SLOT_W      = 5;
  localparam int unsigned SLOT_COUNT  = 26;
  localparam int unsigned OFF_W       = 2;
  localparam int unsigned AXES        = 3;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;

  localparam logic [CFG_W-1:0]  GRID_RESET = 7'd4;
  localparam logic [SLOT_W-1:0] FIRST_SLOT = 5'd0;
  localparam logic [SLOT_W-1:0] LAST_SLOT  = 5'd25;

  // offset codes: value is offset plus one
  localparam logic [OFF_W-1:0] OFF_NEG  = 2'd0;
  localparam logic [OFF_W-1:0] OFF_ZERO = 2'd1;
  localparam logic [OFF_W-1:0] OFF_POS  = 2'd2;

  localparam logic [OFF_W-1:0] OFF_X [SLOT_COUNT] = '{
    OFF_POS, OFF_POS, OFF_ZERO, OFF_NEG, OFF_NEG, OFF_NEG, OFF_ZERO, OFF_POS,
    OFF_POS, OFF_POS, OFF_ZERO, OFF_NEG, OFF_NEG, OFF_NEG, OFF_ZERO, OFF_POS,
    OFF_ZERO,
    OFF_POS, OFF_POS, OFF_ZERO, OFF_NEG, OFF_NEG, OFF_NEG, OFF_ZERO, OFF_POS,
    OFF_ZERO
  };

  localparam logic [OFF_W-1:0] OFF_Y [SLOT_COUNT] = '{
    OFF_ZERO, OFF_POS, OFF_POS, OFF_POS, OFF_ZERO, OFF_NEG, OFF_NEG, OFF_NEG,
    OFF_ZERO, OFF_POS, OFF_POS, OFF_POS, OFF_ZERO, OFF_NEG, OFF_NEG, OFF_NEG,
    OFF_ZERO,
    OFF_ZERO, OFF_POS, OFF_POS, OFF_POS, OFF_ZERO, OFF_NEG, OFF_NEG, OFF_NEG,
    OFF_ZERO
  };

  localparam logic [OFF_W-1:0] OFF_Z [SLOT_COUNT] = '{
    OFF_ZERO, OFF_ZERO, OFF_ZERO, OFF_ZERO, OFF_ZERO, OFF_ZERO, OFF_ZERO, OFF_ZERO,
    OFF_NEG, OFF_NEG, OFF_NEG, OFF_NEG, OFF_NEG, OFF_NEG, OFF_NEG, OFF_NEG,
    OFF_NEG,
    OFF_POS, OFF_POS, OFF_POS, OFF_POS, OFF_POS, OFF_POS, OFF_POS, OFF_POS,
    OFF_POS
  };

endpackage

`default_nettype wire

// File: hw/rtl/pcni_fifo.sv
// ----------------------------------------------------------------------------
// pcni_fifo
// Short queue between the classify front end and the slot back end.
// ----------------------------------------------------------------------------
`default_nettype none

module pcni_fifo
  import pcni_pkg::*;
#(
  parameter int unsigned DW = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire logic [DW-1:0] data_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               empty_o,
  output logic [DW-1:0]      data_o
);

  logic [DW-1:0]     mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign full_o  = (cnt_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign data_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= (QPTR_W+1)'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_cnt_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (do_push && !do_pop) |=> cnt_q == $past(cnt_q) + 1'b1)
    else $error("queue count did not follow a push");

endmodule

`default_nettype wire

// File: hw/rtl/pcni_front.sv
// ----------------------------------------------------------------------------
// pcni_front
// Accepts a home cell, reduces each coordinate modulo the grid size one bit
// per cycle, forms the wrapped coordinates and the home index.
// ----------------------------------------------------------------------------
`default_nettype none

module pcni_front
  import pcni_pkg::*;
#(
  parameter int unsigned MAX_CELLS = 64,
  parameter int unsigned MW        = 7
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [COORD_W-1:0]             cell_x_i,
  input  wire logic [COORD_W-1:0]             cell_y_i,
  input  wire logic [COORD_W-1:0]             cell_z_i,
  input  wire logic [CFG_W-1:0]               grid_size_i,
  output logic                                q_push_o,
  input  wire logic                           q_full_i,
  output logic [IDX_W-1:0]                    home_o,
  output logic [AXES-1:0][AXES-1:0][MW-1:0]   wrap_o,
  output logic [MW-1:0]                       m_o,
  output logic [IDX_W-1:0]                    mm_o,
  output logic                                bad_o
);

  localparam int unsigned CW  = (MW > CFG_W) ? MW : CFG_W;
  localparam int unsigned CNT_W = $clog2(COORD_W);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MOD  = 5'b00010,
    S_WRAP = 5'b00100,
    S_MUL  = 5'b01000,
    S_PUSH = 5'b10000
  } front_state_e;

  front_state_e state_q, state_d;
  logic [CNT_W-1:0]               cnt_q, cnt_d;
  logic [AXES-1:0][COORD_W-1:0]   coord_q;
  logic [AXES-1:0][MW-1:0]        rem_q, rem_d;
  logic [AXES-1:0][AXES-1:0][MW-1:0] wrap_q, wrap_d;
  logic [MW-1:0]                  m_q, m_d;
  logic [IDX_W-1:0]               mm_q;
  logic [IDX_W-1:0]               py_q, pz_q;
  logic                           bad_q, bad_d;
  logic [CW-1:0]                  gs_ext;
  logic                           in_hs;
  logic [MW:0]                    sh [AXES];

  function automatic logic [MW-1:0] dec_wrap(logic [MW-1:0] r, logic [MW-1:0] m);
    dec_wrap = (r == '0) ? m - 1'b1 : r - 1'b1;
  endfunction

  assign in_stall_o = (state_q != S_IDLE);
  assign in_hs      = in_valid_i && !in_stall_o;
  assign gs_ext     = CW'(grid_size_i);

  always_comb begin
    if (grid_size_i == '0) begin
      m_d = MW'(1);
    end else if (gs_ext > CW'(MAX_CELLS)) begin
      m_d = MW'(MAX_CELLS);
    end else begin
      m_d = MW'(gs_ext);
    end
    bad_d = (CW'(cell_x_i) >= CW'(m_d)) || (CW'(cell_y_i) >= CW'(m_d)) ||
            (CW'(cell_z_i) >= CW'(m_d));
  end

  always_comb begin
    for (int a = 0; a < AXES; a++) begin
      sh[a]    = {rem_q[a], coord_q[a][cnt_q]};
      rem_d[a] = (sh[a] >= {1'b0, m_q}) ? MW'(sh[a] - {1'b0, m_q}) : MW'(sh[a]);
      wrap_d[a][OFF_POS]  = rem_q[a];
      wrap_d[a][OFF_ZERO] = dec_wrap(rem_q[a], m_q);
      wrap_d[a][OFF_NEG]  = dec_wrap(dec_wrap(rem_q[a], m_q), m_q);
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_hs) begin
          state_d = S_MOD;
          cnt_d   = CNT_W'(COORD_W - 1);
        end
      end
      S_MOD: begin
        cnt_d = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = S_WRAP;
        end
      end
      S_WRAP: state_d = S_MUL;
      S_MUL:  state_d = S_PUSH;
      S_PUSH: begin
        if (!q_full_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_hs) begin
      coord_q <= {cell_z_i, cell_y_i, cell_x_i};
      m_q     <= m_d;
      bad_q   <= bad_d;
      rem_q   <= '0;
    end else if (state_q == S_MOD) begin
      rem_q <= rem_d;
    end
    if (state_q == S_MOD) begin
      mm_q <= IDX_W'(m_q) * IDX_W'(m_q);
    end
    if (state_q == S_WRAP) begin
      wrap_q <= wrap_d;
    end
    if (state_q == S_MUL) begin
      py_q <= IDX_W'(wrap_q[1][OFF_ZERO]) * IDX_W'(m_q);
      pz_q <= IDX_W'(wrap_q[2][OFF_ZERO]) * mm_q;
    end
  end

  assign q_push_o = (state_q == S_PUSH);
  assign home_o   = IDX_W'(wrap_q[0][OFF_ZERO]) + py_q + pz_q;
  assign wrap_o   = wrap_q;
  assign m_o      = m_q;
  assign mm_o     = mm_q;
  assign bad_o    = bad_q;

endmodule

`default_nettype wire

// File: hw/rtl/pcni_back.sv
// ----------------------------------------------------------------------------
// pcni_back
// Walks the 26 neighbour slots of the queued cell, one result per cycle when
// not stalled, through a product stage and an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pcni_back
  import pcni_pkg::*;
#(
  parameter int unsigned MW = 7
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               q_empty_i,
  output logic                                    q_pop_o,
  input  wire logic [IDX_W-1:0]                   home_i,
  input  wire logic [AXES-1:0][AXES-1:0][MW-1:0]  wrap_i,
  input  wire logic [MW-1:0]                      m_i,
  input  wire logic [IDX_W-1:0]                   mm_i,
  input  wire logic                               bad_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_stall_i,
  output logic [IDX_W-1:0]                        home_index_o,
  output logic [SLOT_W-1:0]                       neighbor_slot_o,
  output logic [IDX_W-1:0]                        neighbor_index_o,
  output logic                                    bad_coord_o,
  output logic                                    last_o
);

  logic              adv;
  logic              take;
  logic [SLOT_W-1:0] slot_q, slot_d;
  logic              s1_valid_q;
  logic [MW-1:0]     s1_vx_q;
  logic [IDX_W-1:0]  s1_py_q, s1_pz_q, s1_home_q;
  logic [SLOT_W-1:0] s1_slot_q;
  logic              s1_bad_q, s1_last_q;
  logic              out_valid_q;
  logic [IDX_W-1:0]  out_home_q, out_idx_q;
  logic [SLOT_W-1:0] out_slot_q;
  logic              out_bad_q, out_last_q;

  assign adv     = !out_valid_q || !out_stall_i;
  assign take    = adv && !q_empty_i;
  assign q_pop_o = take && (slot_q == LAST_SLOT);

  always_comb begin
    slot_d = slot_q;
    if (take) begin
      slot_d = (slot_q == LAST_SLOT) ? FIRST_SLOT : slot_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= FIRST_SLOT;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      slot_q <= slot_d;
      if (adv) begin
        s1_valid_q  <= !q_empty_i;
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      s1_vx_q   <= wrap_i[0][OFF_X[slot_q]];
      s1_py_q   <= IDX_W'(wrap_i[1][OFF_Y[slot_q]]) * IDX_W'(m_i);
      s1_pz_q   <= IDX_W'(wrap_i[2][OFF_Z[slot_q]]) * mm_i;
      s1_home_q <= home_i;
      s1_slot_q <= slot_q;
      s1_bad_q  <= bad_i;
      s1_last_q <= (slot_q == LAST_SLOT);
    end
    if (adv && s1_valid_q) begin
      out_idx_q  <= IDX_W'(s1_vx_q) + s1_py_q + s1_pz_q;
      out_home_q <= s1_home_q;
      out_slot_q <= s1_slot_q;
      out_bad_q  <= s1_bad_q;
      out_last_q <= s1_last_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign home_index_o     = out_home_q;
  assign neighbor_slot_o  = out_slot_q;
  assign neighbor_index_o = out_idx_q;
  assign bad_coord_o      = out_bad_q;
  assign last_o           = out_last_q;

  a_last_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_last_q == (out_slot_q == LAST_SLOT)))
    else $error("last flag and slot disagree");

  a_slot_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_stall_i && !out_last_q) ##1 out_valid_q
      |-> out_slot_q == $past(out_slot_q) + 1'b1)
    else $error("neighbour slots out of sequence");

  a_home_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_stall_i && !out_last_q) ##1 out_valid_q
      |-> out_home_q == $past(out_home_q))
    else $error("home index changed within a cell");

endmodule

`default_nettype wire

// File: hw/rtl/periodic_cell_neighbor_indices_core.sv
// ----------------------------------------------------------------------------
// periodic_cell_neighbor_indices_core
// Neighbour cell indices on a cubic periodic grid: 26 results per home cell.
// ----------------------------------------------------------------------------
// path to first result: front end, queue, product stage, output register
// throughput: one result per cycle unless stalled, set by the slot walk
// front end: no new cell until bit-serial modulo, wrap, multiply, push are done
// reset: grid size returns to 4, queue and pipelines empty, no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_cell_neighbor_indices_core
  import pcni_pkg::*;
#(
  parameter int unsigned MAX_CELLS_PER_AXIS = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CFG_W-1:0]   cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [COORD_W-1:0] cell_x_i,
  input  wire logic [COORD_W-1:0] cell_y_i,
  input  wire logic [COORD_W-1:0] cell_z_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [IDX_W-1:0]        home_index_o,
  output logic [SLOT_W-1:0]       neighbor_slot_o,
  output logic [IDX_W-1:0]        neighbor_index_o,
  output logic                    bad_coord_o,
  output logic                    last_o
);

  localparam int unsigned MW = $clog2(MAX_CELLS_PER_AXIS + 1);
  localparam int unsigned DW = IDX_W + AXES * AXES * MW + MW + IDX_W + 1;

  logic [CFG_W-1:0] grid_size_q;

  logic                              f_push, q_full, q_empty, q_pop;
  logic [IDX_W-1:0]                  f_home, f_mm, b_home, b_mm;
  logic [AXES-1:0][AXES-1:0][MW-1:0] f_wrap, b_wrap;
  logic [MW-1:0]                     f_m, b_m;
  logic                              f_bad, b_bad;
  logic [DW-1:0]                     q_wdata, q_rdata;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_size_q <= GRID_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      grid_size_q <= cfg_data_i;
    end
  end

  pcni_front #(
    .MAX_CELLS (MAX_CELLS_PER_AXIS),
    .MW        (MW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cell_x_i    (cell_x_i),
    .cell_y_i    (cell_y_i),
    .cell_z_i    (cell_z_i),
    .grid_size_i (grid_size_q),
    .q_push_o    (f_push),
    .q_full_i    (q_full),
    .home_o      (f_home),
    .wrap_o      (f_wrap),
    .m_o         (f_m),
    .mm_o        (f_mm),
    .bad_o       (f_bad)
  );

  assign q_wdata = {f_home, f_wrap, f_m, f_mm, f_bad};

  pcni_fifo #(
    .DW (DW)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_push),
    .data_i  (q_wdata),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .data_o  (q_rdata)
  );

  assign {b_home, b_wrap, b_m, b_mm, b_bad} = q_rdata;

  pcni_back #(
    .MW (MW)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_empty_i        (q_empty),
    .q_pop_o          (q_pop),
    .home_i           (b_home),
    .wrap_i           (b_wrap),
    .m_i              (b_m),
    .mm_i             (b_mm),
    .bad_i            (b_bad),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .home_index_o     (home_index_o),
    .neighbor_slot_o  (neighbor_slot_o),
    .neighbor_index_o (neighbor_index_o),
    .bad_coord_o      (bad_coord_o),
    .last_o           (last_o)
  );

endmodule

`default_nettype wire

// File: dv/tb_periodic_cell_neighbor_indices_core.sv
// ----------------------------------------------------------------------------
// tb_periodic_cell_neighbor_indices_core
// Self-checking testbench for the periodic cell neighbour index block. A queue
// of cell requests feeds a clocked driver. Each accepted cell is expanded into
// its 26 expected neighbour results, and a clocked monitor compares every
// result with them in order. Grid sizes are changed only while the block is
// idle, including zero and sizes above the maximum. Sender gaps and receiver
// stalls vary from phase to phase, and one phase has a long output hold-off.
// ----------------------------------------------------------------------------
module tb_periodic_cell_neighbor_indices_core;
  timeunit 1ns;
  timeprecision 1ps;

  import pcni_pkg::*;

  localparam int unsigned MAX_CELLS   = 64;
  localparam int unsigned CYCLE_LIMIT = 600000;
  localparam int unsigned MAX_PRINTS  = 40;
  localparam int unsigned SETTLE      = 40;

  typedef struct {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } cell_req_t;

  typedef struct {
    logic [IDX_W-1:0]  home;
    logic [SLOT_W-1:0] slot;
    logic [IDX_W-1:0]  nidx;
    logic              bad;
    logic              last;
  } neighbor_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CFG_W-1:0]   cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [COORD_W-1:0] cell_x_i;
  logic [COORD_W-1:0] cell_y_i;
  logic [COORD_W-1:0] cell_z_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [IDX_W-1:0]   home_index_o;
  logic [SLOT_W-1:0]  neighbor_slot_o;
  logic [IDX_W-1:0]   neighbor_index_o;
  logic               bad_coord_o;
  logic               last_o;

  cell_req_t   cell_requests[$];
  neighbor_t   expected_neighbors[$];
  logic [CFG_W-1:0] grid_size;
  int unsigned idle_pct;
  int unsigned stall_pct;
  int unsigned hold_left;
  int unsigned cycle_count;
  int unsigned error_count;
  int unsigned cells_sent;
  int unsigned cells_flagged;
  int unsigned results_seen;
  int unsigned grid_writes;
  int unsigned in_stall_cycles;

  periodic_cell_neighbor_indices_core #(
    .MAX_CELLS_PER_AXIS(MAX_CELLS)
  ) dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_data_i       (cfg_data_i),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .cell_x_i         (cell_x_i),
    .cell_y_i         (cell_y_i),
    .cell_z_i         (cell_z_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .home_index_o     (home_index_o),
    .neighbor_slot_o  (neighbor_slot_o),
    .neighbor_index_o (neighbor_index_o),
    .bad_coord_o      (bad_coord_o),
    .last_o           (last_o)
  );

  always #10 clk_i = ~clk_i;

  function automatic int unsigned cells_per_axis();
    if (grid_size == 0) return 1;
    if (grid_size > MAX_CELLS) return MAX_CELLS;
    return grid_size;
  endfunction

  function automatic int unsigned wrap_coord(int unsigned a, int d, int unsigned m);
    return (int'(a) + d - 1 + 2 * int'(m)) % m;
  endfunction

  function automatic logic [IDX_W-1:0] cell_index(int unsigned x, int unsigned y,
                                                  int unsigned z, int dx, int dy,
                                                  int dz, int unsigned m);
    int unsigned full;
    full = wrap_coord(x, dx, m) + wrap_coord(y, dy, m) * m + wrap_coord(z, dz, m) * m * m;
    return full[IDX_W-1:0];
  endfunction

  // ring order: +x, +x+y, +y, -x+y, -x, -x-y, -y, +x-y
  function automatic void predict_neighbors(cell_req_t c);
    int ring_dx[8] = '{1, 1, 0, -1, -1, -1, 0, 1};
    int ring_dy[8] = '{0, 1, 1, 1, 0, -1, -1, -1};
    int unsigned m;
    int dx;
    int dy;
    int dz;
    int r;
    neighbor_t n;
    m = cells_per_axis();
    n.bad  = (c.x >= m) || (c.y >= m) || (c.z >= m);
    n.home = cell_index(c.x, c.y, c.z, 0, 0, 0, m);
    cells_sent++;
    if (n.bad) cells_flagged++;
    for (int s = 0; s < SLOT_COUNT; s++) begin
      if (s < 8) begin
        dz = 0;
        r  = s;
      end else if (s < 17) begin
        dz = -1;
        r  = (s == 16) ? -1 : s - 8;
      end else begin
        dz = 1;
        r  = (s == 25) ? -1 : s - 17;
      end
      dx = (r < 0) ? 0 : ring_dx[r];
      dy = (r < 0) ? 0 : ring_dy[r];
      n.slot = s[SLOT_W-1:0];
      n.nidx = cell_index(c.x, c.y, c.z, dx, dy, dz, m);
      n.last = (s == SLOT_COUNT - 1);
      expected_neighbors.push_back(n);
    end
  endfunction

  task automatic report_mismatch(string field, int unsigned want, int unsigned got);
    error_count++;
    if (error_count <= MAX_PRINTS)
      $display("[%0t] mismatch on %s: expected %0d, got %0d", $time, field, want, got);
  endtask

  // sender
  always @(posedge clk_i) begin : drive_cells
    cell_req_t nxt;
    logic      offer;
    if (rst_ni) begin
      if (in_valid_i && in_stall_o) begin
        in_stall_cycles++;
      end else begin
        if (in_valid_i) predict_neighbors('{cell_x_i, cell_y_i, cell_z_i});
        offer = (cell_requests.size() != 0) && ($urandom_range(0, 99) >= idle_pct);
        if (offer) begin
          nxt = cell_requests.pop_front();
          cell_x_i <= nxt.x;
          cell_y_i <= nxt.y;
          cell_z_i <= nxt.z;
        end
        in_valid_i <= offer;
      end
    end
  end

  // receiver
  always @(posedge clk_i) begin : check_results
    neighbor_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (expected_neighbors.size() == 0) begin
          report_mismatch("result with nothing expected, slot", 0, neighbor_slot_o);
        end else begin
          want = expected_neighbors.pop_front();
          if (home_index_o !== want.home)
            report_mismatch("home_index", want.home, home_index_o);
          if (neighbor_slot_o !== want.slot)
            report_mismatch("neighbor_slot", want.slot, neighbor_slot_o);
          if (neighbor_index_o !== want.nidx)
            report_mismatch("neighbor_index", want.nidx, neighbor_index_o);
          if (bad_coord_o !== want.bad)
            report_mismatch("bad_coord", want.bad, bad_coord_o);
          if (last_o !== want.last)
            report_mismatch("last", want.last, last_o);
        end
      end
      out_stall_i <= (hold_left != 0) || ($urandom_range(0, 99) < stall_pct);
    end
  end

  // long output hold-off
  always @(posedge clk_i) begin
    if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic queue_cell(int unsigned x, int unsigned y, int unsigned z);
    cell_requests.push_back('{x[COORD_W-1:0], y[COORD_W-1:0], z[COORD_W-1:0]});
  endtask

  task automatic set_grid(int unsigned size);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= size[CFG_W-1:0];
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    grid_size = size[CFG_W-1:0];
    grid_writes++;
  endtask

  // wait for every transaction to be accepted and every result to arrive
  task automatic drain();
    do @(negedge clk_i);
    while (cell_requests.size() != 0 || in_valid_i || expected_neighbors.size() != 0);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic run_phase(int unsigned size, int unsigned idle, int unsigned stall,
                           int unsigned count, int unsigned hold);
    int unsigned m;
    set_grid(size);
    m = cells_per_axis();
    idle_pct  <= idle;
    stall_pct <= stall;
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 15)
        queue_cell($urandom_range(0, 63), $urandom_range(0, 63), $urandom_range(0, 63));
      else
        queue_cell($urandom_range(0, m - 1), $urandom_range(0, m - 1),
                   $urandom_range(0, m - 1));
    end
    if (hold != 0) hold_left <= hold;
    drain();
  endtask

  initial begin : run_test
    rst_ni      = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    in_valid_i  = 1'b0;
    cell_x_i    = '0;
    cell_y_i    = '0;
    cell_z_i    = '0;
    out_stall_i = 1'b0;
    idle_pct    = 0;
    stall_pct   = 0;
    hold_left   = 0;
    cycle_count = 0;
    error_count = 0;
    cells_sent  = 0;
    cells_flagged   = 0;
    results_seen    = 0;
    grid_writes     = 0;
    in_stall_cycles = 0;
    grid_size   = GRID_RESET;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset grid size, wrap at both edges and out-of-range coordinates
    queue_cell(0, 0, 0);
    queue_cell(3, 3, 3);
    queue_cell(4, 1, 2);
    queue_cell(2, 0, 3);
    queue_cell(63, 63, 63);
    drain();

    set_grid(MAX_CELLS);
    queue_cell(0, 0, 0);
    queue_cell(63, 63, 63);
    queue_cell(63, 0, 0);
    queue_cell(0, 63, 0);
    queue_cell(0, 0, 63);
    queue_cell(21, 42, 10);
    drain();

    // size zero behaves as a single cell
    set_grid(0);
    queue_cell(0, 0, 0);
    queue_cell(1, 0, 0);
    queue_cell(0, 0, 63);
    drain();

    // oversized grid clamps to the maximum
    set_grid(127);
    queue_cell(63, 63, 63);
    queue_cell(5, 6, 7);
    drain();

    set_grid(1);
    queue_cell(0, 0, 0);
    drain();
    set_grid(2);
    queue_cell(1, 1, 0);
    queue_cell(2, 0, 1);
    drain();
    set_grid(3);
    queue_cell(2, 2, 2);
    queue_cell(0, 1, 2);
    drain();

    run_phase(MAX_CELLS, 0, 0, 50, 0);
    run_phase(5, 68, 0, 50, 0);
    run_phase(MAX_CELLS, 0, 68, 50, 0);
    run_phase($urandom_range(1, MAX_CELLS), 31, 31, 50, 0);
    run_phase(127, 0, 0, 50, 400);
    run_phase(2, 0, 68, 50, 0);
    run_phase(3, 68, 0, 50, 0);
    run_phase($urandom_range(0, 127), 31, 31, 60, 0);

    if (expected_neighbors.size() != 0)
      report_mismatch("results still pending at end, count", 0, expected_neighbors.size());

    $display("covered %0d cells (%0d with out-of-range coordinates) over %0d grid sizes",
             cells_sent, cells_flagged, grid_writes + 1);
    $display("checked %0d neighbour results, input back-pressure on %0d cycles",
             results_seen, in_stall_cycles);
    if (error_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/pcni_pkg.sv
hw/rtl/pcni_fifo.sv
hw/rtl/pcni_front.sv
hw/rtl/pcni_back.sv
hw/rtl/periodic_cell_neighbor_indices_core.sv
dv/tb_periodic_cell_neighbor_indices_core.sv
